// ===== rtl/pwfm_pkg.sv =====
// Package for the pulse width frequency meter.
// Holds the controller states, character and register codes, widths and the
// command and status structs shared by the controller, datapath and top level.
package pwfm_pkg;

  localparam int unsigned NUM_W      = 16;  // scale numerator / frequency width
  localparam int unsigned HOLD_W     = 20;  // holdoff counter width
  localparam int unsigned CHAR_W     = 8;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 20;
  localparam int unsigned STEP_W     = $clog2(NUM_W);
  localparam int unsigned BCD_DIGITS = 5;
  localparam int unsigned BCD_W      = 4 * BCD_DIGITS;

  localparam logic [NUM_W-1:0]  SCALE_RESET   = 16'd3906;
  localparam logic [HOLD_W-1:0] HOLDOFF_RESET = 20'd1000000;

  localparam logic [CHAR_W-1:0] CH_ZERO = 8'd48;
  localparam logic [CHAR_W-1:0] CH_CR   = 8'd13;
  localparam logic [CHAR_W-1:0] CH_LF   = 8'd10;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SCALE   = 2'd0,
    CFG_HOLDOFF = 2'd1
  } cfg_reg_e;

  typedef enum logic [2:0] {
    CI_HUND = 3'd0,
    CI_TENS = 3'd1,
    CI_ONES = 3'd2,
    CI_CR   = 3'd3,
    CI_LF   = 3'd4
  } char_idx_e;

  typedef enum logic [2:0] {
    ST_WAIT_LOW  = 3'd0,
    ST_WAIT_RISE = 3'd1,
    ST_COUNT     = 3'd2,
    ST_HOLD      = 3'd3,
    ST_DIV       = 3'd4,
    ST_LOAD      = 3'd5,
    ST_SPLIT     = 3'd6,
    ST_EMIT      = 3'd7
  } state_e;

  typedef struct packed {
    logic clr_count;
    logic inc_count;
    logic load_hold;
    logic dec_hold;
    logic div_start;
    logic div_step;
    logic split_load;
    logic split_step;
    logic emit_adv;
  } dp_cmd_t;

  typedef struct packed {
    logic hold_zero;
    logic step_last;
    logic char_last;
  } dp_sts_t;

endpackage

// ===== rtl/pulse_width_frequency_meter_top.sv =====
// Pulse width frequency meter, top level.
// Joins pwfm_ctrl and pwfm_dp; uses pwfm_pkg for types and constants.
//
// Takes one pin sample per word on the input channel. It waits for a low
// sample, then a rising edge, then counts prescaled ticks (PRESCALE samples
// per tick, COUNT_BITS-bit count that wraps) while the pin stays high. On
// the falling edge it divides scale_numerator by the tick count (a zero count
// gives scale_numerator) and sends five words: hundreds, tens and ones as
// ASCII digits (hundreds is frequency/100 modulo 256, unclamped), then CR and
// LF, with last_char_o marking the LF. The next holdoff_ticks samples are
// then consumed and ignored. Rate: one sample per cycle while measuring and
// in holdoff. After the falling-edge sample the input stalls for the report:
// the restoring divider (one quotient bit per cycle), a load state, the
// binary to BCD converter and the output words, which wait out any output
// stall. The configuration port is always ready; write it only while the
// meter is idle.
module pulse_width_frequency_meter_top #(
  parameter int unsigned PRESCALE   = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic                            pin_level_i,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [pwfm_pkg::CHAR_W-1:0]     out_char_o,
  output logic                            last_char_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [pwfm_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [pwfm_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  pwfm_pkg::dp_cmd_t cmd;
  pwfm_pkg::dp_sts_t sts;

  // configuration writes never wait
  assign cfg_ready_o = 1'b1;

  pwfm_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .pin_level_i (pin_level_i),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o)
  );

  pwfm_dp #(
    .PRESCALE   (PRESCALE),
    .COUNT_BITS (COUNT_BITS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_char_o  (out_char_o),
    .last_char_o (last_char_o)
  );

`ifndef SYNTHESIS
  // hold the input off while a report is being sent
  a_no_input_during_report: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> in_stall_o)
    else $error("input taken while a report is pending");

  // the marked word is always the line feed
  a_last_is_lf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && last_char_o) |-> (out_char_o == pwfm_pkg::CH_LF))
    else $error("last word is not a line feed");

  // drop valid once the line feed has gone
  a_report_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_stall_i && last_char_o) |=> !out_valid_o)
    else $error("output continues past the line feed");
`endif

endmodule

// ===== rtl/pwfm_ctrl.sv =====
// Controller of the pulse width frequency meter.
// Sequences edge detection, division, decimal split, output and holdoff; depends on
// pwfm_pkg for states and the command and status structs.
module pwfm_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              pin_level_i,
  input  logic              out_stall_i,
  input  pwfm_pkg::dp_sts_t sts_i,
  output pwfm_pkg::dp_cmd_t cmd_o,
  output logic              in_stall_o,
  output logic              out_valid_o
);

  pwfm_pkg::state_e state_q, state_d;
  logic             in_acc;
  logic             out_acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= pwfm_pkg::ST_WAIT_LOW;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b0;
    out_valid_o = 1'b0;
    in_acc      = in_valid_i;
    out_acc     = 1'b0;
    unique case (state_q)
      pwfm_pkg::ST_WAIT_LOW: begin
        if (in_acc && !pin_level_i) begin
          state_d = pwfm_pkg::ST_WAIT_RISE;
        end
      end
      pwfm_pkg::ST_WAIT_RISE: begin
        if (in_acc && pin_level_i) begin
          cmd_o.clr_count = 1'b1;
          state_d         = pwfm_pkg::ST_COUNT;
        end
      end
      pwfm_pkg::ST_COUNT: begin
        if (in_acc) begin
          if (pin_level_i) begin
            cmd_o.inc_count = 1'b1;
          end else begin
            cmd_o.load_hold = 1'b1;
            cmd_o.div_start = 1'b1;
            state_d         = pwfm_pkg::ST_DIV;
          end
        end
      end
      pwfm_pkg::ST_HOLD: begin
        if (in_acc) begin
          if (!sts_i.hold_zero) begin
            cmd_o.dec_hold = 1'b1;
          end else if (!pin_level_i) begin
            state_d = pwfm_pkg::ST_WAIT_RISE;
          end else begin
            state_d = pwfm_pkg::ST_WAIT_LOW;
          end
        end
      end
      pwfm_pkg::ST_DIV: begin
        in_stall_o     = 1'b1;
        in_acc         = 1'b0;
        cmd_o.div_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = pwfm_pkg::ST_LOAD;
        end
      end
      pwfm_pkg::ST_LOAD: begin
        in_stall_o       = 1'b1;
        in_acc           = 1'b0;
        cmd_o.split_load = 1'b1;
        state_d          = pwfm_pkg::ST_SPLIT;
      end
      pwfm_pkg::ST_SPLIT: begin
        in_stall_o       = 1'b1;
        in_acc           = 1'b0;
        cmd_o.split_step = 1'b1;
        if (sts_i.step_last) begin
          state_d = pwfm_pkg::ST_EMIT;
        end
      end
      pwfm_pkg::ST_EMIT: begin
        in_stall_o     = 1'b1;
        in_acc         = 1'b0;
        out_valid_o    = 1'b1;
        out_acc        = !out_stall_i;
        cmd_o.emit_adv = out_acc;
        if (out_acc && sts_i.char_last) begin
          state_d = pwfm_pkg::ST_HOLD;
        end
      end
      default: begin
        state_d = pwfm_pkg::ST_WAIT_LOW;
      end
    endcase
  end

endmodule

// ===== rtl/pwfm_dp.sv =====
// Datapath of the pulse width frequency meter.
// Holds config registers, prescaler, tick and holdoff counters, the restoring
// divider, the binary to BCD converter and the character select; uses pwfm_pkg.
module pwfm_dp #(
  parameter int unsigned PRESCALE   = 256,
  parameter int unsigned COUNT_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [pwfm_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pwfm_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  input  pwfm_pkg::dp_cmd_t                   cmd_i,
  output pwfm_pkg::dp_sts_t                   sts_o,
  output logic [pwfm_pkg::CHAR_W-1:0]         out_char_o,
  output logic                                last_char_o
);

  localparam int unsigned PS_W = $clog2(PRESCALE + 1);
  localparam logic [PS_W-1:0] PS_TOP = PS_W'(PRESCALE);
  localparam int unsigned NW = pwfm_pkg::NUM_W;

  logic [NW-1:0]                  scale_q;
  logic [pwfm_pkg::HOLD_W-1:0]    holdoff_q;
  logic [PS_W-1:0]                ps_q;
  logic [PS_W-1:0]                ps_inc;
  logic [COUNT_BITS-1:0]          ticks_q;
  logic [pwfm_pkg::HOLD_W-1:0]    hold_q;
  logic [pwfm_pkg::STEP_W-1:0]    step_q;
  logic [COUNT_BITS-1:0]          rem_q;
  logic [NW-1:0]                  quo_q;
  logic [COUNT_BITS:0]            shifted;
  logic [COUNT_BITS+1:0]          diff;
  logic [pwfm_pkg::BCD_W-1:0]     bcd_q;
  logic [pwfm_pkg::BCD_W-1:0]     bcd_adj;
  logic [2:0]                     chr_q;
  logic [9:0]                     hund_full;
  logic [pwfm_pkg::CHAR_W-1:0]    hund;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scale_q   <= pwfm_pkg::SCALE_RESET;
      holdoff_q <= pwfm_pkg::HOLDOFF_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        pwfm_pkg::CFG_SCALE:   scale_q   <= cfg_data_i[NW-1:0];
        pwfm_pkg::CFG_HOLDOFF: holdoff_q <= cfg_data_i[pwfm_pkg::HOLD_W-1:0];
        default: ;
      endcase
    end
  end

  assign ps_inc = ps_q + PS_W'(1);

  // prescaler, tick and holdoff counters
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ps_q    <= '0;
      ticks_q <= '0;
      hold_q  <= '0;
    end else begin
      if (cmd_i.clr_count) begin
        ps_q    <= '0;
        ticks_q <= '0;
      end else if (cmd_i.inc_count) begin
        if (ps_inc == PS_TOP) begin
          ps_q    <= '0;
          ticks_q <= ticks_q + COUNT_BITS'(1);
        end else begin
          ps_q <= ps_inc;
        end
      end
      if (cmd_i.load_hold) begin
        hold_q <= holdoff_q;
      end else if (cmd_i.dec_hold) begin
        hold_q <= hold_q - pwfm_pkg::HOLD_W'(1);
      end
    end
  end

  // restoring divider step
  assign shifted = {rem_q, quo_q[NW-1]};
  assign diff    = {1'b0, shifted} - {2'b00, ticks_q};

  // double dabble add-3 correction on each digit
  always_comb begin
    for (int i = 0; i < pwfm_pkg::BCD_DIGITS; i++) begin
      if (bcd_q[4*i +: 4] >= 4'd5) begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4] + 4'd3;
      end else begin
        bcd_adj[4*i +: 4] = bcd_q[4*i +: 4];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      rem_q <= '0;
      quo_q <= scale_q;
    end else if (cmd_i.div_step) begin
      if (!diff[COUNT_BITS+1]) begin
        rem_q <= diff[COUNT_BITS-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b1};
      end else begin
        rem_q <= shifted[COUNT_BITS-1:0];
        quo_q <= {quo_q[NW-2:0], 1'b0};
      end
    end else if (cmd_i.split_load) begin
      // a zero tick count gives the numerator itself
      if (ticks_q == '0) begin
        quo_q <= scale_q;
      end
      bcd_q <= '0;
    end else if (cmd_i.split_step) begin
      bcd_q <= {bcd_adj[pwfm_pkg::BCD_W-2:0], quo_q[NW-1]};
      quo_q <= {quo_q[NW-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
      chr_q  <= '0;
    end else begin
      if (cmd_i.div_start || cmd_i.split_load) begin
        step_q <= '0;
      end else if (cmd_i.div_step || cmd_i.split_step) begin
        step_q <= step_q + pwfm_pkg::STEP_W'(1);
      end
      if (cmd_i.split_load) begin
        chr_q <= pwfm_pkg::CI_HUND;
      end else if (cmd_i.emit_adv) begin
        chr_q <= chr_q + 3'd1;
      end
    end
  end

  // hundreds is frequency / 100 taken modulo 256, not clamped to one digit
  assign hund_full = 10'(bcd_q[19:16]) * 10'd100 + 10'(bcd_q[15:12]) * 10'd10
                   + 10'(bcd_q[11:8]);
  assign hund      = hund_full[pwfm_pkg::CHAR_W-1:0];

  always_comb begin
    last_char_o = 1'b0;
    unique case (chr_q)
      pwfm_pkg::CI_HUND: out_char_o = hund + pwfm_pkg::CH_ZERO;
      pwfm_pkg::CI_TENS: out_char_o = {4'd0, bcd_q[7:4]} + pwfm_pkg::CH_ZERO;
      pwfm_pkg::CI_ONES: out_char_o = {4'd0, bcd_q[3:0]} + pwfm_pkg::CH_ZERO;
      pwfm_pkg::CI_CR:   out_char_o = pwfm_pkg::CH_CR;
      pwfm_pkg::CI_LF: begin
        out_char_o  = pwfm_pkg::CH_LF;
        last_char_o = 1'b1;
      end
      default: out_char_o = pwfm_pkg::CH_LF;
    endcase
  end

  assign sts_o.hold_zero = (hold_q == '0);
  assign sts_o.step_last = (step_q == pwfm_pkg::STEP_W'(NW - 1));
  assign sts_o.char_last = (chr_q == pwfm_pkg::CI_LF);

endmodule
